FILE: sv/tcwe_pkg.sv
// Package for the text console write engine: command codes, screen sizes,
// cell constants and the state machine type. No dependencies.
`default_nettype none
package tcwe_pkg;
  localparam int unsigned ScreenColumns = 80;
  localparam int unsigned ScreenRows = 25;
  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [7:0] SpaceCode = 8'd32;
  localparam logic [7:0] ResetAttr = 8'h0F;

  localparam logic [2:0] KindPut = 3'd0;
  localparam logic [2:0] KindBksp = 3'd1;
  localparam logic [2:0] KindSetCur = 3'd2;
  localparam logic [2:0] KindClear = 3'd3;
  localparam logic [2:0] KindPutAt = 3'd4;
  localparam logic [2:0] KindRead = 3'd5;

  typedef enum logic [2:0] {
    StInit, StIdle, StRead, StScrollRd, StScrollWr, StFill, StOut
  } state_e;
endpackage
`default_nettype wire

FILE: sv/tcwe_ram.sv
// Screen cell memory: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module tcwe_ram #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = 11
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [15:0]      wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [15:0]      rdata_o
);
  logic [15:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: sv/text_console_write_engine_unit.sv
// Text console write engine top level: state machine around a screen memory.
// Depends on tcwe_pkg and tcwe_ram.
// Put, backspace, set cursor, put at cell and unused kinds go from decode (StIdle)
// to the result register (StOut); an on-screen read cell adds a memory read (StRead).
// A newline or a wrap on the last row scrolls: each moved cell is read (StScrollRd)
// and written a row up (StScrollWr), then the bottom row is filled. Clear writes one
// cell a cycle. Reset: the cursor clears and a clearing pass writes 0x0F20 to every
// cell; no item is accepted during it, configuration writes are taken.
`default_nettype none
module text_console_write_engine_unit
  import tcwe_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = ScreenColumns,
  parameter int unsigned SCREEN_ROWS = ScreenRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // kind[2:0], char_code[10:3], col_index[17:11], row_index[22:18], zero fill
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cursor_row[4:0], cursor_col[11:5], cursor_linear[22:12], cell_word[38:23]
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);
  localparam int unsigned Cells = SCREEN_ROWS * SCREEN_COLUMNS;
  // The scroll pointer runs one row past the last cell while it fills the bottom row.
  localparam int unsigned AddrW = $clog2(Cells + SCREEN_COLUMNS);
  localparam int unsigned MemW = $clog2(Cells);
  localparam int unsigned RowW = $clog2(SCREEN_ROWS);
  localparam int unsigned ColW = $clog2(SCREEN_COLUMNS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] Cols = AddrW'(SCREEN_COLUMNS);
  localparam logic [AddrW-1:0] ScrollEnd = AddrW'(Cells - SCREEN_COLUMNS);

  state_e state_q, state_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [7:0] color_q;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [15:0] word_q, word_d;
  logic [15:0] fill_q, fill_d;
  logic [AddrW-1:0] lin_q, lin_d;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;

  tcwe_ram #(.Depth(Cells), .AddrW(MemW)) u_ram (
    .clk_i,
    .we_i(we),
    .waddr_i(MemW'(waddr)),
    .wdata_i(wdata),
    .raddr_i(MemW'(raddr)),
    .rdata_o(rdata)
  );

  logic [2:0] kind;
  logic [7:0] ch;
  logic [6:0] in_col;
  logic [4:0] in_row;
  logic on_screen;
  logic [AddrW-1:0] in_cell, cur_cell;
  assign kind = s_axis_tdata[2:0];
  assign ch = s_axis_tdata[10:3];
  assign in_col = s_axis_tdata[17:11];
  assign in_row = s_axis_tdata[22:18];
  assign on_screen = (32'(in_col) < SCREEN_COLUMNS) && (32'(in_row) < SCREEN_ROWS);
  assign in_cell = AddrW'(in_row) * Cols + AddrW'(in_col);
  assign cur_cell = lin_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) color_q <= ResetAttr;
    else if (cfg_valid_i) color_q <= cfg_data_i;
  end

  // Linear cursor tracked alongside row/column to avoid a multiply per item.
  always_comb begin
    state_d = state_q;
    row_d = row_q;
    col_d = col_q;
    lin_d = lin_q;
    ptr_d = ptr_q;
    word_d = word_q;
    fill_d = fill_q;
    we = 1'b0;
    waddr = ptr_q;
    wdata = fill_q;
    raddr = ptr_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      StInit, StFill: begin
        // Sweep the screen with the fill word.
        we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == LastAddr) state_d = StOut;
        if (state_q == StInit && ptr_q == LastAddr) state_d = StIdle;
      end
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          word_d = '0;
          state_d = StOut;
          case (kind)
            KindPut: begin
              if (ch != NewlineCode) begin
                we = 1'b1;
                waddr = cur_cell;
                wdata = {color_q, ch};
              end
              if (ch == NewlineCode || 32'(col_q) == SCREEN_COLUMNS - 1) begin
                col_d = '0;
                if (32'(row_q) == SCREEN_ROWS - 1) begin
                  lin_d = ScrollEnd;
                  ptr_d = Cols;
                  fill_d = {color_q, SpaceCode};
                  state_d = StScrollRd;
                end else begin
                  row_d = row_q + 1'b1;
                  lin_d = cur_cell - AddrW'(col_q) + Cols;
                end
              end else begin
                col_d = col_q + 1'b1;
                lin_d = cur_cell + 1'b1;
              end
            end
            KindBksp: begin
              if (col_q != '0 || row_q != '0) begin
                we = 1'b1;
                waddr = cur_cell - 1'b1;
                wdata = {color_q, SpaceCode};
                lin_d = cur_cell - 1'b1;
                if (col_q != '0) col_d = col_q - 1'b1;
                else begin
                  row_d = row_q - 1'b1;
                  col_d = ColW'(SCREEN_COLUMNS - 1);
                end
              end
            end
            KindSetCur: begin
              if (on_screen) begin
                row_d = RowW'(in_row);
                col_d = ColW'(in_col);
                lin_d = in_cell;
              end
            end
            KindClear: begin
              row_d = '0;
              col_d = '0;
              lin_d = '0;
              ptr_d = '0;
              fill_d = {color_q, SpaceCode};
              state_d = StFill;
            end
            KindPutAt: begin
              if (on_screen) begin
                we = 1'b1;
                waddr = in_cell;
                wdata = {color_q, ch};
              end
            end
            KindRead: begin
              if (on_screen) begin
                raddr = in_cell;
                state_d = StRead;
              end
            end
            default: ;
          endcase
        end
      end
      StRead: begin
        word_d = rdata;
        state_d = StOut;
      end
      StScrollRd: begin
        // Read the cell one row below; past the last row fill the bottom row.
        if (ptr_q > LastAddr) begin
          we = 1'b1;
          waddr = ptr_q - Cols;
          ptr_d = ptr_q + 1'b1;
          if (ptr_q - Cols == LastAddr) state_d = StOut;
        end else begin
          raddr = ptr_q;
          state_d = StScrollWr;
        end
      end
      StScrollWr: begin
        we = 1'b1;
        waddr = ptr_q - Cols;
        wdata = rdata;
        ptr_d = ptr_q + 1'b1;
        state_d = StScrollRd;
      end
      StOut: begin
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      row_q <= '0;
      col_q <= '0;
      lin_q <= '0;
      ptr_q <= '0;
      fill_q <= {ResetAttr, SpaceCode};
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      col_q <= col_d;
      lin_q <= lin_d;
      ptr_q <= ptr_d;
      fill_q <= fill_d;
    end
  end
  always_ff @(posedge clk_i) word_q <= word_d;

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = {1'b0, word_q, 11'(lin_q), 7'(col_q), 5'(row_q)};

`ifndef SYNTH
  a_lin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(lin_q) == 32'(row_q) * SCREEN_COLUMNS + 32'(col_q))
    else $error("linear cursor mismatch");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready during result");
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < SCREEN_ROWS && 32'(col_q) < SCREEN_COLUMNS) else $error("cursor off screen");
`endif
endmodule
`default_nettype wire
